/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* sv/epp_rbcs_pkg.sv */
// ----------------------------------------------------------------------------
// epp_rbcs_pkg
// Types and codes for the rack-bus to EPP port cycle sequencer.
// ----------------------------------------------------------------------------
package epp_rbcs_pkg;

	// Most port cycles one request byte can expand to
	localparam int LIST_DEPTH = 7;
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

	// Cycle kinds
	localparam logic [2:0] KIND_ADDR   = 3'd0;
	localparam logic [2:0] KIND_WRITE  = 3'd1;
	localparam logic [2:0] KIND_READ   = 3'd2;
	localparam logic [2:0] KIND_TOGGLE = 3'd3;
	localparam logic [2:0] KIND_NONE   = 3'd4;

	// Request status
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_BAD_RACK   = 3'd1;
	localparam logic [2:0] ST_BAD_OFFSET = 3'd2;
	localparam logic [2:0] ST_BAD_LENGTH = 3'd3;
	localparam logic [2:0] ST_RANGE      = 3'd4;

	localparam logic [7:0] RACK_HI_MASK = 8'hF0;
	localparam logic [7:0] OFFSET_MAX   = 8'hFE;
	localparam logic [3:0] RACK_NONE    = 4'hF;
	localparam logic [7:0] RACK_SEL_ADDR = 8'h00;

	// Port direction
	localparam logic DIR_WRITE = 1'b0;
	localparam logic DIR_READ  = 1'b1;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] rack_number;
		logic [7:0] start_offset;
		logic [7:0] byte_count;
		logic       first_byte;
		logic [7:0] write_byte;
	} item_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data;
	} entry_t;

	typedef struct packed {
		entry_t [LIST_DEPTH-1:0] entries;
		logic [CNT_W-1:0]        count;
		logic [2:0]              status;
		logic                    done;
	} batch_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data;
		logic [2:0] status;
		logic       last;
		logic       done;
	} result_t;

endpackage

/* sv/epp_rbcs_expand.sv */
// ----------------------------------------------------------------------------
// epp_rbcs_expand
// Checks a request byte and expands it into its list of port cycles; holds
// the selected rack, port direction and request progress.
// ----------------------------------------------------------------------------
module epp_rbcs_expand (
	input  logic                 clk,
	input  logic                 arst_n,
	input  epp_rbcs_pkg::item_t  item,
	input  logic                 commit,
	output epp_rbcs_pkg::batch_t batch
);

	logic [3:0] rack_q;
	logic       dir_q;
	logic [7:0] bytes_done_q;
	logic [2:0] req_err_q;

	logic [3:0] rack_d;
	logic       dir_d;
	logic [7:0] bytes_done_d;
	logic [2:0] req_err_d;

	always_comb begin : expand_p
		logic                      new_req;
		logic [2:0]                chk;
		logic [7:0]                idx;
		logic                      range_mode;
		logic [epp_rbcs_pkg::CNT_W-1:0] n;
		logic                      dir;
		logic [8:0]                end_sum;

		// request check, in priority order
		end_sum = {1'b0, item.start_offset} + {1'b0, item.byte_count};
		priority if ((item.rack_number & epp_rbcs_pkg::RACK_HI_MASK) != 8'h00)
			chk = epp_rbcs_pkg::ST_BAD_RACK;
		else if (item.start_offset == 8'h00 || item.start_offset > epp_rbcs_pkg::OFFSET_MAX)
			chk = epp_rbcs_pkg::ST_BAD_OFFSET;
		else if (item.byte_count == 8'h00)
			chk = epp_rbcs_pkg::ST_BAD_LENGTH;
		else if (item.action[0] && item.byte_count > 8'd1
				&& end_sum > {1'b0, epp_rbcs_pkg::OFFSET_MAX})
			chk = epp_rbcs_pkg::ST_RANGE;
		else
			chk = epp_rbcs_pkg::ST_OK;

		// a stray continuation with nothing under way starts a request too
		new_req    = item.first_byte || bytes_done_q == 8'h00;
		req_err_d  = new_req ? chk : req_err_q;
		idx        = new_req ? 8'h00 : bytes_done_q;
		range_mode = item.action[0] && item.byte_count > 8'd1;

		batch        = '0;
		batch.status = req_err_d;
		batch.done   = ({1'b0, idx} + 9'd1) >= {1'b0, item.byte_count};
		bytes_done_d = batch.done ? 8'h00 : idx + 8'd1;

		n      = '0;
		dir    = dir_q;
		rack_d = rack_q;

		if (req_err_d != epp_rbcs_pkg::ST_OK) begin
			batch.entries[n] = '{kind: epp_rbcs_pkg::KIND_NONE, data: 8'h00};
			n = n + 1'b1;
		end else begin
			if (idx == 8'h00 && rack_q != item.rack_number[3:0]) begin
				if (dir != epp_rbcs_pkg::DIR_WRITE) begin
					batch.entries[n] = '{kind: epp_rbcs_pkg::KIND_TOGGLE, data: 8'h00};
					n = n + 1'b1;
					dir = epp_rbcs_pkg::DIR_WRITE;
				end
				batch.entries[n] = '{kind: epp_rbcs_pkg::KIND_ADDR,
					data: epp_rbcs_pkg::RACK_SEL_ADDR};
				n = n + 1'b1;
				batch.entries[n] = '{kind: epp_rbcs_pkg::KIND_WRITE, data: item.rack_number};
				n = n + 1'b1;
				batch.entries[n] = '{kind: epp_rbcs_pkg::KIND_WRITE, data: item.rack_number};
				n = n + 1'b1;
				rack_d = item.rack_number[3:0];
			end
			// address once per request, or per byte in range mode (wraps mod 256)
			if (range_mode || idx == 8'h00) begin
				if (dir != epp_rbcs_pkg::DIR_WRITE) begin
					batch.entries[n] = '{kind: epp_rbcs_pkg::KIND_TOGGLE, data: 8'h00};
					n = n + 1'b1;
					dir = epp_rbcs_pkg::DIR_WRITE;
				end
				batch.entries[n] = '{kind: epp_rbcs_pkg::KIND_ADDR,
					data: item.start_offset + idx};
				n = n + 1'b1;
			end
			if (item.action[1]) begin
				if (dir != epp_rbcs_pkg::DIR_WRITE) begin
					batch.entries[n] = '{kind: epp_rbcs_pkg::KIND_TOGGLE, data: 8'h00};
					n = n + 1'b1;
					dir = epp_rbcs_pkg::DIR_WRITE;
				end
				batch.entries[n] = '{kind: epp_rbcs_pkg::KIND_WRITE, data: item.write_byte};
				n = n + 1'b1;
				batch.entries[n] = '{kind: epp_rbcs_pkg::KIND_WRITE, data: item.write_byte};
				n = n + 1'b1;
			end else begin
				if (dir != epp_rbcs_pkg::DIR_READ) begin
					batch.entries[n] = '{kind: epp_rbcs_pkg::KIND_TOGGLE, data: 8'h00};
					n = n + 1'b1;
					dir = epp_rbcs_pkg::DIR_READ;
				end
				batch.entries[n] = '{kind: epp_rbcs_pkg::KIND_READ, data: 8'h00};
				n = n + 1'b1;
			end
		end

		batch.count = n;
		dir_d       = dir;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rack_q       <= epp_rbcs_pkg::RACK_NONE;
			dir_q        <= epp_rbcs_pkg::DIR_WRITE;
			bytes_done_q <= 8'h00;
			req_err_q    <= epp_rbcs_pkg::ST_OK;
		end else if (commit) begin
			rack_q       <= rack_d;
			dir_q        <= dir_d;
			bytes_done_q <= bytes_done_d;
			req_err_q    <= req_err_d;
		end
	end

endmodule

/* sv/epp_rbcs_drain.sv */
// ----------------------------------------------------------------------------
// epp_rbcs_drain
// Result register: holds one item's port cycle list and hands it out one
// beat per cycle while res_ready is high.
// ----------------------------------------------------------------------------
module epp_rbcs_drain (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  epp_rbcs_pkg::batch_t  batch,
	output logic                  free,
	output logic                  res_valid,
	input  logic                  res_ready,
	output epp_rbcs_pkg::result_t res
);

	epp_rbcs_pkg::entry_t [epp_rbcs_pkg::LIST_DEPTH-1:0] entries_s2;
	logic [epp_rbcs_pkg::CNT_W-1:0] remain_q;
	logic [2:0]                     status_s2;
	logic                           done_s2;
	logic                           last;
	logic                           pop;

	assign res_valid = remain_q != '0;
	assign last      = remain_q == epp_rbcs_pkg::CNT_W'(1);
	assign pop       = res_valid && res_ready;
	assign free      = !res_valid || (pop && last);

	assign res.kind   = entries_s2[0].kind;
	assign res.data   = entries_s2[0].data;
	assign res.status = status_s2;
	assign res.last   = last;
	assign res.done   = done_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remain_q <= '0;
		end else if (load) begin
			remain_q <= batch.count;
		end else if (pop) begin
			remain_q <= remain_q - 1'b1;
		end
	end

	// payload: load a fresh list, or advance by one entry per beat
	always_ff @(posedge clk) begin
		if (load) begin
			entries_s2 <= batch.entries;
			status_s2  <= batch.status;
			done_s2    <= batch.done;
		end else if (pop) begin
			for (int i = 0; i < epp_rbcs_pkg::LIST_DEPTH - 1; i++)
				entries_s2[i] <= entries_s2[i+1];
		end
	end

endmodule

/* sv/epp_rack_bus_cycle_sequencer.sv */
// ----------------------------------------------------------------------------
// epp_rack_bus_cycle_sequencer
// Turns rack-bus request bytes into EPP port cycles.
// ----------------------------------------------------------------------------
// Path: a taken item is held in the input register until the result register
//   is free, then its port cycle list is loaded there and offered from it.
// Flow: an item yields 1..7 port cycles, one beat per cycle while out_ready is
//   high; the input register takes the next item while a list drains.
// Reset: asynchronous; rack 15 selected, write direction, no request open.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module epp_rack_bus_cycle_sequencer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] action,
	input  logic [7:0] rack_number,
	input  logic [7:0] start_offset,
	input  logic [7:0] byte_count,
	input  logic       first_byte,
	input  logic [7:0] write_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] cycle_kind,
	output logic [7:0] cycle_byte,
	output logic [2:0] status,
	output logic       last_of_item,
	output logic       request_done
);

	epp_rbcs_pkg::item_t   item_s1;
	logic                  valid_s1;
	epp_rbcs_pkg::batch_t  batch;
	epp_rbcs_pkg::result_t res;
	logic                  free;
	logic                  take;
	logic                  advance;

	assign in_ready = !valid_s1 || free;
	assign take     = in_valid && in_ready;
	assign advance  = valid_s1 && free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= '{action: action, rack_number: rack_number,
				start_offset: start_offset, byte_count: byte_count,
				first_byte: first_byte, write_byte: write_byte};
		end
	end

	epp_rbcs_expand u_expand (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.commit (advance),
		.batch  (batch)
	);

	epp_rbcs_drain u_drain (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.batch     (batch),
		.free      (free),
		.res_valid (out_valid),
		.res_ready (out_ready),
		.res       (res)
	);

	assign cycle_kind   = res.kind;
	assign cycle_byte   = res.data;
	assign status       = res.status;
	assign last_of_item = res.last;
	assign request_done = res.done;

	// a rejected request byte yields exactly one result, with no port cycle
	`ASSERT_IMPLY(a_err_single, clk, arst_n,
		out_valid && status != epp_rbcs_pkg::ST_OK,
		cycle_kind == epp_rbcs_pkg::KIND_NONE && last_of_item,
		"error result is not a single no-cycle beat")
	// the input side stalls only while an item waits in the input register
	`ASSERT_IMPLY(a_stall_cause, clk, arst_n, !in_ready, valid_s1,
		"input stalled with empty input register")
	// a list is never loaded over results still waiting
	`ASSERT_IMPLY(a_no_overwrite, clk, arst_n, advance && out_valid,
		out_ready && last_of_item, "result list overwritten before drained")

endmodule
